[sv/bbgd_pkg.sv]
package bbgd_pkg;

  // Fixed field widths
  localparam int unsigned CHAN_W  = 8;
  localparam int unsigned COORD_W = 10;
  localparam int unsigned CENTER_W = 11;
  localparam int unsigned EPOCH_W = 4;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 11;
  localparam int unsigned IN_DATA_W = 24;
  localparam int unsigned OUT_DATA_W = 48;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCAN_COLUMNS_FIRST = 3'd0,
    CFG_LINE_LENGTH        = 3'd1,
    CFG_LINE_COUNT         = 3'd2,
    CFG_ORIGIN_X           = 3'd3,
    CFG_ORIGIN_Y           = 3'd4,
    CFG_BRIGHT_LEVEL       = 3'd5,
    CFG_GAP_LINES          = 3'd6
  } cfg_reg_e;

  // Register reset values
  localparam logic [6:0]  LINE_LENGTH_RST  = 7'd60;
  localparam logic [10:0] LINE_COUNT_RST   = 11'd640;
  localparam logic [7:0]  BRIGHT_LEVEL_RST = 8'd16;
  localparam logic [3:0]  GAP_LINES_RST    = 4'd10;

  // One line buffer entry: brightness of the two previous lines at one position
  typedef struct packed {
    logic [EPOCH_W-1:0] epoch;
    logic               older;
    logic               newer;
  } line_entry_t;

  // Pixel handed from the scan stage to the tracking stage
  typedef struct packed {
    logic               cur;
    logic               eol;
    logic               eor;
    logic               n_ge3;
    logic               m_ge3;
    logic               m_ge1;
    logic [COORD_W-1:0] minor_c;
    logic [COORD_W-1:0] major_r;
    logic [EPOCH_W-1:0] epoch;
  } scan_item_t;

  // Reported object
  typedef struct packed {
    logic [COORD_W-1:0]  size_y;
    logic [COORD_W-1:0]  size_x;
    logic [CENTER_W-1:0] center_y;
    logic [CENTER_W-1:0] center_x;
  } result_t;

endpackage

[sv/bbgd_line_mem.sv]
module bbgd_line_mem #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic                    clk_i,
  input  logic                    we_i,
  input  logic [AW-1:0]           waddr_i,
  input  bbgd_pkg::line_entry_t   wdata_i,
  input  logic                    re_i,
  input  logic [AW-1:0]           raddr_i,
  output bbgd_pkg::line_entry_t   rdata_o
);

  bbgd_pkg::line_entry_t mem_q [DEPTH];
  bbgd_pkg::line_entry_t rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sv/bbgd_scan.sv]
module bbgd_scan #(
  parameter int unsigned MAX_LINE_LENGTH = 64,
  parameter int unsigned MAX_LINE_COUNT  = 1024,
  parameter int unsigned AW = 6,
  parameter int unsigned MW = 10
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic [6:0]                            cfg_line_length_i,
  input  logic [10:0]                           cfg_line_count_i,
  input  logic [bbgd_pkg::CHAN_W-1:0]           cfg_bright_level_i,
  input  logic                                  in_valid_i,
  input  logic [bbgd_pkg::IN_DATA_W-1:0]        in_data_i,
  input  logic                                  room_i,
  output logic                                  in_ready_o,
  output logic                                  mem_re_o,
  output logic [AW-1:0]                         mem_raddr_o,
  output logic                                  mem_we_o,
  output logic [AW-1:0]                         mem_waddr_o,
  output bbgd_pkg::line_entry_t                 mem_wdata_o,
  input  bbgd_pkg::line_entry_t                 wr_entry_i,
  output logic                                  item_valid_o,
  output bbgd_pkg::scan_item_t                  item_o
);

  localparam int unsigned LenW = AW + 1;
  localparam int unsigned CntW = MW + 1;

  logic [AW-1:0]                  n_q, n_d;
  logic [MW-1:0]                  m_q, m_d;
  logic [bbgd_pkg::EPOCH_W-1:0]   epoch_q, epoch_d;
  logic                           clear_q, clear_d;
  logic [AW-1:0]                  clr_addr_q, clr_addr_d;
  logic                           item_valid_q;
  bbgd_pkg::scan_item_t           item_q, item_d;
  logic [AW-1:0]                  addr_q;

  logic [LenW-1:0] len_eff, n_inc;
  logic [CntW-1:0] cnt_eff, m_inc;
  logic            accept, eol, eor, bright;
  logic [31:0]     n_dec, m_dec;

  // Clamp line length and line count into range
  always_comb begin
    if (32'(cfg_line_length_i) < 32'd3) begin
      len_eff = LenW'(3);
    end else if (32'(cfg_line_length_i) > MAX_LINE_LENGTH) begin
      len_eff = LenW'(MAX_LINE_LENGTH);
    end else begin
      len_eff = LenW'(cfg_line_length_i);
    end
    if (32'(cfg_line_count_i) < 32'd3) begin
      cnt_eff = CntW'(3);
    end else if (32'(cfg_line_count_i) > MAX_LINE_COUNT) begin
      cnt_eff = CntW'(MAX_LINE_COUNT);
    end else begin
      cnt_eff = CntW'(cfg_line_count_i);
    end
  end

  assign in_ready_o = !clear_q && room_i;
  assign accept     = in_valid_i && in_ready_o;
  assign n_inc      = {1'b0, n_q} + LenW'(1);
  assign m_inc      = {1'b0, m_q} + CntW'(1);
  assign eol        = n_inc >= len_eff;
  assign eor        = eol && (m_inc >= cnt_eff);
  assign n_dec      = 32'(n_q) - 32'd1;
  assign m_dec      = 32'(m_q) - 32'd1;

  // A pixel is bright when every channel reaches the level
  assign bright = (in_data_i[7:0] >= cfg_bright_level_i) &&
                  (in_data_i[15:8] >= cfg_bright_level_i) &&
                  (in_data_i[23:16] >= cfg_bright_level_i);

  // Advance scan position, region epoch and clearing sweep
  always_comb begin
    n_d        = n_q;
    m_d        = m_q;
    epoch_d    = epoch_q;
    clear_d    = clear_q;
    clr_addr_d = clr_addr_q;

    item_d.cur     = bright;
    item_d.eol     = eol;
    item_d.eor     = eor;
    item_d.n_ge3   = 32'(n_q) >= 32'd3;
    item_d.m_ge3   = 32'(m_q) >= 32'd3;
    item_d.m_ge1   = 32'(m_q) >= 32'd1;
    item_d.minor_c = n_dec[bbgd_pkg::COORD_W-1:0];
    item_d.major_r = m_dec[bbgd_pkg::COORD_W-1:0];
    item_d.epoch   = epoch_q;

    if (clear_q) begin
      if (clr_addr_q == AW'(MAX_LINE_LENGTH - 1)) begin
        clear_d    = 1'b0;
        clr_addr_d = '0;
      end else begin
        clr_addr_d = clr_addr_q + AW'(1);
      end
    end

    if (accept) begin
      if (eol) begin
        n_d = '0;
        if (eor) begin
          m_d = '0;
          // Stale entries are told apart by epoch; sweep when the epoch wraps
          if (epoch_q == '1) begin
            epoch_d = '0;
            clear_d = 1'b1;
          end else begin
            epoch_d = epoch_q + 1'b1;
          end
        end else begin
          m_d = m_q + MW'(1);
        end
      end else begin
        n_d = n_q + AW'(1);
      end
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q          <= '0;
      m_q          <= '0;
      epoch_q      <= '0;
      clear_q      <= 1'b1;
      clr_addr_q   <= '0;
      item_valid_q <= 1'b0;
    end else begin
      n_q          <= n_d;
      m_q          <= m_d;
      epoch_q      <= epoch_d;
      clear_q      <= clear_d;
      clr_addr_q   <= clr_addr_d;
      item_valid_q <= accept;
    end
  end

  // Item payload follows the read into the tracking stage
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_d;
      addr_q <= n_q;
    end
  end

  // Read ahead at the accepted position; the sweep overrides the write back
  assign mem_re_o    = accept;
  assign mem_raddr_o = n_q;
  assign mem_we_o    = clear_q || item_valid_q;
  assign mem_waddr_o = clear_q ? clr_addr_q : addr_q;
  assign mem_wdata_o = clear_q ? '0 : wr_entry_i;

  assign item_valid_o = item_valid_q;
  assign item_o       = item_q;

  // The sweep always leaves the epoch at zero
  a_sweep_epoch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(clear_q) |-> epoch_q == '0)
    else $error("clearing sweep ended with a non-zero epoch");

  // Position never leaves the buffer
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_valid_q |-> 32'(addr_q) < MAX_LINE_LENGTH)
    else $error("write back address beyond line buffer");

endmodule

[sv/bbgd_track.sv]
module bbgd_track (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_scan_columns_first_i,
  input  logic [bbgd_pkg::COORD_W-1:0]    cfg_origin_x_i,
  input  logic [bbgd_pkg::COORD_W-1:0]    cfg_origin_y_i,
  input  logic [3:0]                      cfg_gap_lines_i,
  input  logic                            item_valid_i,
  input  bbgd_pkg::scan_item_t            item_i,
  input  bbgd_pkg::line_entry_t           rd_entry_i,
  output bbgd_pkg::line_entry_t           wr_entry_o,
  output logic                            res_valid_o,
  output bbgd_pkg::result_t               res_o
);

  localparam int unsigned CW = bbgd_pkg::COORD_W;

  logic [1:0]    recent_q, recent_d;
  logic          win1_older_q, win1_newer_q, win2_older_q;
  logic [CW-1:0] box_xl_q, box_xl_d, box_xh_q, box_xh_d;
  logic [CW-1:0] box_yl_q, box_yl_d, box_yh_q, box_yh_d;
  logic          open_q, open_d, had_q, had_d;
  logic [3:0]    empty_q, empty_d;

  logic          ent_ok, ent_older, ent_newer, hit;
  logic [CW-1:0] hx, hy, xl_n, xh_n, yl_n, yh_n;
  logic          open_now, had_now, gap_step, emit;
  logic [3:0]    empty_now, empty_inc, gap_eff;
  logic [CW:0]   sum_x, sum_y;

  // Entries from an earlier region read as dark
  assign ent_ok    = rd_entry_i.epoch == item_i.epoch;
  assign ent_older = ent_ok && rd_entry_i.older;
  assign ent_newer = ent_ok && rd_entry_i.newer;

  // Shift the line history at this position
  always_comb begin
    wr_entry_o.epoch = item_i.epoch;
    wr_entry_o.older = ent_newer;
    wr_entry_o.newer = item_i.cur;
  end

  // Centre pixel one line up and one back, tested with its four diagonals
  assign hit = item_i.m_ge3 && item_i.n_ge3 && item_i.cur && recent_q[1] &&
               win1_newer_q && win2_older_q && ent_older;
  assign hx  = cfg_scan_columns_first_i ? item_i.major_r : item_i.minor_c;
  assign hy  = cfg_scan_columns_first_i ? item_i.minor_c : item_i.major_r;

  assign xl_n = (hit && hx < box_xl_q) ? hx : box_xl_q;
  assign xh_n = (hit && hx > box_xh_q) ? hx : box_xh_q;
  assign yl_n = (hit && hy < box_yl_q) ? hy : box_yl_q;
  assign yh_n = (hit && hy > box_yh_q) ? hy : box_yh_q;

  assign open_now  = open_q || hit;
  assign had_now   = had_q || hit;
  assign empty_now = hit ? 4'd0 : empty_q;
  assign empty_inc = empty_now + 4'd1;
  assign gap_eff   = (cfg_gap_lines_i == 4'd0) ? 4'd1 : cfg_gap_lines_i;
  assign gap_step  = item_i.eol && item_i.m_ge1 && open_now && !had_now;
  assign emit      = item_valid_i && gap_step && (empty_inc >= gap_eff);

  // Report the box as centre plus origin and extent
  assign sum_x = {1'b0, box_xl_q} + {1'b0, box_xh_q};
  assign sum_y = {1'b0, box_yl_q} + {1'b0, box_yh_q};
  always_comb begin
    res_o.center_x = {1'b0, cfg_origin_x_i} + {1'b0, sum_x[CW:1]};
    res_o.center_y = {1'b0, cfg_origin_y_i} + {1'b0, sum_y[CW:1]};
    res_o.size_x   = box_xh_q - box_xl_q;
    res_o.size_y   = box_yh_q - box_yl_q;
  end
  assign res_valid_o = emit;

  // Grow the box, count empty lines, close or drop the object
  always_comb begin
    recent_d = recent_q;
    box_xl_d = box_xl_q;
    box_xh_d = box_xh_q;
    box_yl_d = box_yl_q;
    box_yh_d = box_yh_q;
    open_d   = open_q;
    had_d    = had_q;
    empty_d  = empty_q;
    if (item_valid_i) begin
      box_xl_d = xl_n;
      box_xh_d = xh_n;
      box_yl_d = yl_n;
      box_yh_d = yh_n;
      open_d   = open_now;
      had_d    = had_now;
      empty_d  = empty_now;
      recent_d = {recent_q[0], item_i.cur};
      if (item_i.eol) begin
        recent_d = 2'b00;
        had_d    = 1'b0;
        if (gap_step) begin
          empty_d = empty_inc;
        end
        if (emit || item_i.eor) begin
          box_xl_d = '1;
          box_xh_d = '0;
          box_yl_d = '1;
          box_yh_d = '0;
          open_d   = 1'b0;
          empty_d  = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      recent_q <= 2'b00;
      box_xl_q <= '1;
      box_xh_q <= '0;
      box_yl_q <= '1;
      box_yh_q <= '0;
      open_q   <= 1'b0;
      had_q    <= 1'b0;
      empty_q  <= '0;
    end else begin
      recent_q <= recent_d;
      box_xl_q <= box_xl_d;
      box_xh_q <= box_xh_d;
      box_yl_q <= box_yl_d;
      box_yh_q <= box_yh_d;
      open_q   <= open_d;
      had_q    <= had_d;
      empty_q  <= empty_d;
    end
  end

  // Hold the previous-line entries of the last two positions
  always_ff @(posedge clk_i) begin
    if (item_valid_i) begin
      win2_older_q <= win1_older_q;
      win1_older_q <= ent_older;
      win1_newer_q <= ent_newer;
    end
  end

  // A report always closes an object that is open
  a_emit_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> open_q)
    else $error("object reported while none is open");

  // A report leaves the box cleared
  a_emit_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> !open_q && box_xh_q == '0 && box_yh_q == '0)
    else $error("box not cleared after report");

endmodule

[sv/bbgd_out_fifo.sv]
module bbgd_out_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  bbgd_pkg::result_t  push_data_i,
  input  logic               pop_i,
  output logic [1:0]         count_o,
  output logic               out_valid_o,
  output bbgd_pkg::result_t  out_data_o
);

  bbgd_pkg::result_t slot_q [2];
  logic              wr_ptr_q, rd_ptr_q;
  logic [1:0]        cnt_q;
  logic              do_pop;

  assign do_pop = pop_i && (cnt_q != 2'd0);

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, do_pop};
    end
  end

  // Store the item
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign count_o     = cnt_q;
  assign out_valid_o = cnt_q != 2'd0;
  assign out_data_o  = slot_q[rd_ptr_q];

  // Input back-pressure must keep the queue from overflowing
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && cnt_q == 2'd2 && !pop_i))
    else $error("result queue overflow");

endmodule

[sv/blob_box_gap_detector.sv]
// Bounding-box gap detector over one difference region.
// Slave stream: one pixel item per handshake, in scan order, line_length
// pixels per line and line_count lines per region. Master stream: one item
// per closed object (centre x/y with region origin added, box size x/y).
// Configuration: write cfg_wdata_i to register cfg_index_i while cfg_we_i is
// high; write only while no item is in flight.
// Throughput: one pixel per clock while s_axis_tready is high. Each pixel
// reads the two-line brightness history at its position from a line memory
// with one read and one write port and writes it back in the next cycle;
// the read for the next pixel overlaps that write. A result is computed from
// the registered last pixel of the line that completes the gap, then queued.
// Stalls: results wait in a two-entry queue; s_axis_tready drops while that
// queue might not take a result from the pixel in flight.
// Reset: a sweep clears all MAX_LINE_LENGTH line entries with s_axis_tready
// low; the same sweep repeats once every 16 regions, at the region's end.
module blob_box_gap_detector #(
  parameter int unsigned MAX_LINE_LENGTH = 64,
  parameter int unsigned MAX_LINE_COUNT  = 1024
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [7:0] chan_blue, [15:8] chan_green, [23:16] chan_red
  input  logic [bbgd_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [10:0] center_x, [21:11] center_y, [31:22] size_x, [41:32] size_y, rest zero
  output logic [bbgd_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  input  logic                                cfg_we_i,
  input  logic [bbgd_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [bbgd_pkg::CFG_DATA_W-1:0]     cfg_wdata_i
);

  localparam int unsigned AW = $clog2(MAX_LINE_LENGTH);
  localparam int unsigned MW = $clog2(MAX_LINE_COUNT);

  logic        scan_columns_first_q;
  logic [6:0]  line_length_q;
  logic [10:0] line_count_q;
  logic [9:0]  origin_x_q, origin_y_q;
  logic [7:0]  bright_level_q;
  logic [3:0]  gap_lines_q;

  logic                   mem_re, mem_we;
  logic [AW-1:0]          mem_raddr, mem_waddr;
  bbgd_pkg::line_entry_t  mem_wdata, mem_rdata, wr_entry;
  logic                   item_valid, res_valid, room;
  bbgd_pkg::scan_item_t   item;
  bbgd_pkg::result_t      res, out_res;
  logic [1:0]             q_count;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_columns_first_q <= 1'b0;
      line_length_q        <= bbgd_pkg::LINE_LENGTH_RST;
      line_count_q         <= bbgd_pkg::LINE_COUNT_RST;
      origin_x_q           <= '0;
      origin_y_q           <= '0;
      bright_level_q       <= bbgd_pkg::BRIGHT_LEVEL_RST;
      gap_lines_q          <= bbgd_pkg::GAP_LINES_RST;
    end else if (cfg_we_i) begin
      case (bbgd_pkg::cfg_reg_e'(cfg_index_i))
        bbgd_pkg::CFG_SCAN_COLUMNS_FIRST: scan_columns_first_q <= cfg_wdata_i[0];
        bbgd_pkg::CFG_LINE_LENGTH:        line_length_q        <= cfg_wdata_i[6:0];
        bbgd_pkg::CFG_LINE_COUNT:         line_count_q         <= cfg_wdata_i[10:0];
        bbgd_pkg::CFG_ORIGIN_X:           origin_x_q           <= cfg_wdata_i[9:0];
        bbgd_pkg::CFG_ORIGIN_Y:           origin_y_q           <= cfg_wdata_i[9:0];
        bbgd_pkg::CFG_BRIGHT_LEVEL:       bright_level_q       <= cfg_wdata_i[7:0];
        bbgd_pkg::CFG_GAP_LINES:          gap_lines_q          <= cfg_wdata_i[3:0];
        default: ;
      endcase
    end
  end

  // Leave room in the queue for a result from the pixel in flight
  assign room = (q_count == 2'd0) || ((q_count == 2'd1) && !item_valid);

  bbgd_scan #(
    .MAX_LINE_LENGTH (MAX_LINE_LENGTH),
    .MAX_LINE_COUNT  (MAX_LINE_COUNT),
    .AW              (AW),
    .MW              (MW)
  ) u_scan (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_line_length_i  (line_length_q),
    .cfg_line_count_i   (line_count_q),
    .cfg_bright_level_i (bright_level_q),
    .in_valid_i         (s_axis_tvalid),
    .in_data_i          (s_axis_tdata),
    .room_i             (room),
    .in_ready_o         (s_axis_tready),
    .mem_re_o           (mem_re),
    .mem_raddr_o        (mem_raddr),
    .mem_we_o           (mem_we),
    .mem_waddr_o        (mem_waddr),
    .mem_wdata_o        (mem_wdata),
    .wr_entry_i         (wr_entry),
    .item_valid_o       (item_valid),
    .item_o             (item)
  );

  bbgd_line_mem #(
    .DEPTH (MAX_LINE_LENGTH),
    .AW    (AW)
  ) u_line_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  bbgd_track u_track (
    .clk_i                    (clk_i),
    .rst_ni                   (rst_ni),
    .cfg_scan_columns_first_i (scan_columns_first_q),
    .cfg_origin_x_i           (origin_x_q),
    .cfg_origin_y_i           (origin_y_q),
    .cfg_gap_lines_i          (gap_lines_q),
    .item_valid_i             (item_valid),
    .item_i                   (item),
    .rd_entry_i               (mem_rdata),
    .wr_entry_o               (wr_entry),
    .res_valid_o              (res_valid),
    .res_o                    (res)
  );

  bbgd_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .pop_i       (m_axis_tready),
    .count_o     (q_count),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (out_res)
  );

  assign m_axis_tdata = {6'd0, out_res};

endmodule
